// ----- rtl/hsc_pkg.sv -----
// hsc_pkg: shared types and constants of the hsv skin pixel classifier.
// Used by hsc_feature and hsv_skin_pixel_classifier; depends on nothing.
`default_nettype none

package hsc_pkg;

  // channel and register widths
  localparam int unsigned CH_W      = 8;
  localparam int unsigned HUE_W     = 9;
  localparam int unsigned SAT_W     = 10;
  localparam int unsigned HUE_NUM_W = 17;  // hue times d, below 360 * 255
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 10;

  // reset values of the thresholds
  localparam logic [HUE_W-1:0] HUE_LOW_RST  = 9'd0;
  localparam logic [HUE_W-1:0] HUE_HIGH_RST = 9'd50;
  localparam logic [SAT_W-1:0] SAT_LOW_RST  = 10'd230;
  localparam logic [SAT_W-1:0] SAT_HIGH_RST = 10'd680;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_LOW  = 8'd0,
    REG_HUE_HIGH = 8'd1,
    REG_SAT_LOW  = 8'd2,
    REG_SAT_HIGH = 8'd3
  } cfg_reg_t;

  // per-pixel features handed from the hue/sat front end
  typedef struct packed {
    logic                 grey;     // max equals min, never skin
    logic [CH_W-1:0]      vmax;     // value
    logic [CH_W-1:0]      delta;    // max minus min
    logic [HUE_NUM_W-1:0] hue_num;  // hue in degrees times delta, wrapped
  } hsc_feat_t;

endpackage

`default_nettype wire

// ----- rtl/hsc_feature.sv -----
// hsc_feature: combinational front end, max/min, delta and hue numerator.
// Depends on hsc_pkg.
`default_nettype none

module hsc_feature (
  input  wire logic [hsc_pkg::CH_W-1:0] red,
  input  wire logic [hsc_pkg::CH_W-1:0] green,
  input  wire logic [hsc_pkg::CH_W-1:0] blue,
  output hsc_pkg::hsc_feat_t            feat
);
  import hsc_pkg::*;

  logic [CH_W-1:0]        vmax;
  logic [CH_W-1:0]        vmin;
  logic [CH_W-1:0]        delta;
  logic signed [11:0]     sect;     // blue sector reaches 5 * 255
  logic signed [11:0]     r_s;
  logic signed [11:0]     g_s;
  logic signed [11:0]     b_s;
  logic signed [11:0]     d_s;
  logic signed [17:0]     num_s;
  logic signed [17:0]     wrap_s;
  logic signed [17:0]     hue_s;

  // max and min of the three channels
  always_comb begin
    vmax = red;
    vmin = red;
    if (green > vmax) vmax = green;
    if (blue > vmax)  vmax = blue;
    if (green < vmin) vmin = green;
    if (blue < vmin)  vmin = blue;
    delta = vmax - vmin;
  end

  assign r_s = $signed({4'b0000, red});
  assign g_s = $signed({4'b0000, green});
  assign b_s = $signed({4'b0000, blue});
  assign d_s = $signed({4'b0000, delta});

  // sector term, blue beats green beats red on ties with max
  always_comb begin
    if (blue == vmax) begin
      sect = (d_s <<< 2) + r_s - g_s;
    end else if (green == vmax) begin
      sect = (d_s <<< 1) + b_s - r_s;
    end else begin
      sect = g_s - b_s;
    end
  end

  // scale to degrees and wrap a negative hue by a full turn
  assign num_s  = 18'(sect) * 18'sd60;
  assign wrap_s = $signed({1'b0, 17'(delta) * 17'd360});
  assign hue_s  = (num_s < 0) ? num_s + wrap_s : num_s;

  assign feat = {(delta == '0), vmax, delta, hue_s[HUE_NUM_W-1:0]};

endmodule

`default_nettype wire

// ----- rtl/hsv_skin_pixel_classifier.sv -----
// hsv_skin_pixel_classifier: one pixel per cycle while the output is not stalled,
// three register stages: input register, feature register (hue numerator,
// value, delta) and result register. Throughput is one item per cycle when
// out_tready is held high; each stage holds on its own under stall.
// Synchronous active-low reset empties the pipeline and loads the default
// thresholds. Depends on hsc_pkg and hsc_feature.
`default_nettype none

module hsv_skin_pixel_classifier (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata: red [7:0], green [15:8], blue [23:16]
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [3*hsc_pkg::CH_W-1:0]      in_tdata,
  // out_tdata: skin [0], zero [7:1]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [7:0]                           out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hsc_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import hsc_pkg::*;

  logic [HUE_W-1:0]     hue_low_r;
  logic [HUE_W-1:0]     hue_high_r;
  logic [SAT_W-1:0]     sat_low_r;
  logic [SAT_W-1:0]     sat_high_r;

  logic                 v0_r;
  logic                 v1_r;
  logic                 v2_r;
  logic                 rdy1;
  logic                 rdy2;
  logic [CH_W-1:0]      red_r;
  logic [CH_W-1:0]      green_r;
  logic [CH_W-1:0]      blue_r;
  hsc_feat_t            feat_nxt;
  hsc_feat_t            feat_r;
  logic                 skin_nxt;
  logic                 skin_r;

  logic [HUE_NUM_W-1:0] hue_lo_p;
  logic [HUE_NUM_W-1:0] hue_hi_p;
  logic [17:0]          sat_d_p;
  logic [17:0]          sat_lo_p;
  logic [17:0]          sat_hi_p;

  // configuration writes, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= HUE_LOW_RST;
      hue_high_r <= HUE_HIGH_RST;
      sat_low_r  <= SAT_LOW_RST;
      sat_high_r <= SAT_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HUE_LOW:  hue_low_r  <= cfg_data[HUE_W-1:0];
        REG_HUE_HIGH: hue_high_r <= cfg_data[HUE_W-1:0];
        REG_SAT_LOW:  sat_low_r  <= cfg_data[SAT_W-1:0];
        REG_SAT_HIGH: sat_high_r <= cfg_data[SAT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage readiness, a stage moves when empty or when the next one moves
  assign rdy2      = !v2_r || out_tready;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = !v0_r || rdy1;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_tready) v0_r <= in_tvalid;
      if (rdy1)      v1_r <= v0_r;
      if (rdy2)      v2_r <= v1_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      red_r   <= in_tdata[CH_W-1:0];
      green_r <= in_tdata[2*CH_W-1:CH_W];
      blue_r  <= in_tdata[3*CH_W-1:2*CH_W];
    end
  end

  // hue and saturation front end
  hsc_feature u_feature (
    .red   (red_r),
    .green (green_r),
    .blue  (blue_r),
    .feat  (feat_nxt)
  );

  always_ff @(posedge clk) begin
    if (v0_r && rdy1) feat_r <= feat_nxt;
  end

  // threshold products, bounds scaled by delta or by value
  assign hue_lo_p = HUE_NUM_W'(hue_low_r) * HUE_NUM_W'(feat_r.delta);
  assign hue_hi_p = HUE_NUM_W'(hue_high_r) * HUE_NUM_W'(feat_r.delta);
  assign sat_d_p  = 18'(feat_r.delta) * 18'd1000;
  assign sat_lo_p = 18'(sat_low_r) * 18'(feat_r.vmax);
  assign sat_hi_p = 18'(sat_high_r) * 18'(feat_r.vmax);

  assign skin_nxt = !feat_r.grey
                 && (feat_r.hue_num >= hue_lo_p) && (feat_r.hue_num <= hue_hi_p)
                 && (sat_d_p >= sat_lo_p) && (sat_d_p <= sat_hi_p);

  // result register
  always_ff @(posedge clk) begin
    if (v1_r && rdy2) skin_r <= skin_nxt;
  end

  assign out_tvalid = v2_r;
  assign out_tdata  = {7'b0000000, skin_r};

  // a grey pixel leaving the feature stage gives a zero result
  a_grey_not_skin: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && rdy2 && feat_r.grey) |=> (out_tvalid && !out_tdata[0]))
    else $error("grey pixel classified as skin");

  // a stalled feature stage keeps its item
  a_feat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(feat_r)))
    else $error("feature stage lost its item under stall");

  // reset loads the default thresholds
  a_cfg_reset: assert property (@(posedge clk)
    !rst_n |=> (hue_low_r == HUE_LOW_RST && hue_high_r == HUE_HIGH_RST
                && sat_low_r == SAT_LOW_RST && sat_high_r == SAT_HIGH_RST))
    else $error("thresholds not at reset values");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// testbench: self-checking bench for hsv_skin_pixel_classifier, random pixels
// under several threshold settings, each result checked against a built-in predictor.
// Depends on hsc_pkg and the classifier RTL only.
`default_nettype none

module testbench;
  import hsc_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int END_CYCLES  = 8;
  localparam int RAND_ITEMS  = 313;   // per threshold setting
  localparam int NUM_PHASES  = 6;
  localparam int MAX_PRINTS  = 50;

  // register indexes that the block must ignore
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LOW = 8'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_TOP = 8'hFF;

  // tdata layout: red in the low byte
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [3*CH_W-1:0]    in_tdata   = '0;   // red [7:0], green [15:8], blue [23:16]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;         // skin [0], zero [7:1]
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;

  // threshold copy used for prediction
  logic [HUE_W-1:0] thr_hue_low  = HUE_LOW_RST;
  logic [HUE_W-1:0] thr_hue_high = HUE_HIGH_RST;
  logic [SAT_W-1:0] thr_sat_low  = SAT_LOW_RST;
  logic [SAT_W-1:0] thr_sat_high = SAT_HIGH_RST;

  pixel_t pixel_q[$];
  bit     skin_expect_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count     = 0;
  int cycle_count   = 0;
  int pixels_sent   = 0;
  int results_seen  = 0;
  int skin_seen     = 0;
  int settings_used = 1;

  hsv_skin_pixel_classifier u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // skin decision with exact cross-multiplied bounds
  function automatic bit predict_skin(pixel_t px);
    int r, g, b, v, m, d, num;
    r = px.red;
    g = px.green;
    b = px.blue;
    v = r;
    m = r;
    if (g > v) v = g;
    if (b > v) v = b;
    if (g < m) m = g;
    if (b < m) m = b;
    d = v - m;
    if (d == 0) return 1'b0;
    // last channel equal to max picks the sector
    num = 0;
    if (r == v) num = 60 * (g - b);
    if (g == v) num = 60 * (2 * d + b - r);
    if (b == v) num = 60 * (4 * d + r - g);
    if (num < 0) num += 360 * d;
    return (num >= int'(thr_hue_low) * d) && (num <= int'(thr_hue_high) * d) &&
           (1000 * d >= int'(thr_sat_low) * v) && (1000 * d <= int'(thr_sat_high) * v);
  endfunction

  function automatic pixel_t make_pix(int r, int g, int b);
    pixel_t px;
    px.red   = 8'(r);
    px.green = 8'(g);
    px.blue  = 8'(b);
    return px;
  endfunction

  // append a pixel to the pending queue
  function automatic void add_pixel(input pixel_t px);
    pixel_q.insert(pixel_q.size(), px);
  endfunction

  // random pixel, mostly aimed at the current hue and saturation bounds
  function automatic pixel_t random_pixel();
    int kind, a, c, v, d, m, h, x, s;
    kind = $urandom_range(99);
    if (kind < 8) begin
      a = $urandom_range(255);
      return make_pix(a, a, a);
    end
    if (kind < 23)
      return make_pix($urandom_range(255), $urandom_range(255), $urandom_range(255));
    if (kind < 38) begin
      // two channels tied, either as max or as min
      a = $urandom_range(255);
      c = $urandom_range(255);
      case ($urandom_range(2))
        0:       return make_pix(a, a, c);
        1:       return make_pix(a, c, a);
        default: return make_pix(c, a, a);
      endcase
    end
    // build from value, delta and hue near a bound
    v = $urandom_range(1, 255);
    case ($urandom_range(2))
      0:       s = thr_sat_low;
      1:       s = thr_sat_high;
      default: s = $urandom_range(1000);
    endcase
    d = (s * v) / 1000 + $urandom_range(2) - 1;
    if (d < 0) d = 0;
    if (d > v) d = v;
    m = v - d;
    case ($urandom_range(2))
      0:       h = thr_hue_low;
      1:       h = thr_hue_high;
      default: h = $urandom_range(359);
    endcase
    h = h % 360;
    x = ((h % 60) * d + $urandom_range(59)) / 60;
    case (h / 60)
      0:       return make_pix(v, m + x, m);
      1:       return make_pix(v - x, v, m);
      2:       return make_pix(m, v, m + x);
      3:       return make_pix(m, v - x, v);
      4:       return make_pix(m + x, m, v);
      default: return make_pix(v, m, v - x);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // pixel driver, predicts on each accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        skin_expect_q.insert(skin_expect_q.size(), predict_skin(pixel_t'(in_tdata)));
        pixels_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pixel_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        skin_seen += out_tdata[0];
        if (skin_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %02h", out_tdata));
        end else begin
          bit exp_skin;
          exp_skin = skin_expect_q.pop_front();
          if (out_tdata[0] !== exp_skin || out_tdata[7:1] !== 7'd0)
            report_mismatch($sformatf("result %0d: tdata %02h, skin expected %0d",
                                      results_seen, out_tdata, exp_skin));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, skin_expect_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // wait until every queued pixel is sent and every result checked
  task automatic drain();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_tvalid || skin_expect_q.size() != 0);
  endtask

  // one register write; valid stays high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_HUE_LOW:  thr_hue_low  = val[HUE_W-1:0];
      REG_HUE_HIGH: thr_hue_high = val[HUE_W-1:0];
      REG_SAT_LOW:  thr_sat_low  = val[SAT_W-1:0];
      REG_SAT_HIGH: thr_sat_high = val[SAT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input int hlo, input int hhi, input int slo, input int shi);
    write_reg(REG_HUE_LOW,  CFG_DAT_W'(hlo));
    write_reg(REG_HUE_HIGH, CFG_DAT_W'(hhi));
    write_reg(REG_SAT_LOW,  CFG_DAT_W'(slo));
    write_reg(REG_SAT_HIGH, CFG_DAT_W'(shi));
  endtask

  // sequence: reset, directed pixels, then threshold phases
  initial begin
    int hlo, slo;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 10;
    recv_idle_pct = 52;

    // directed pixels under reset thresholds
    add_pixel(make_pix(0, 0, 0));        // black
    add_pixel(make_pix(255, 255, 255));  // white
    add_pixel(make_pix(90, 90, 90));     // grey
    add_pixel(make_pix(255, 0, 0));      // pure red, full saturation
    add_pixel(make_pix(0, 255, 0));      // green sector
    add_pixel(make_pix(0, 0, 255));      // blue sector
    add_pixel(make_pix(255, 0, 255));    // red and blue tied, blue wins
    add_pixel(make_pix(255, 255, 0));    // red and green tied, green wins
    add_pixel(make_pix(0, 255, 255));    // green and blue tied, blue wins
    add_pixel(make_pix(200, 150, 100));  // typical skin tone
    add_pixel(make_pix(100, 85, 77));    // saturation exactly at low bound
    add_pixel(make_pix(100, 85, 78));    // just under low bound
    add_pixel(make_pix(100, 50, 32));    // saturation exactly at high bound
    add_pixel(make_pix(100, 50, 31));    // just over high bound
    add_pixel(make_pix(200, 190, 140));  // hue exactly at high bound
    add_pixel(make_pix(200, 191, 140));  // hue just over high bound
    add_pixel(make_pix(200, 140, 140));  // hue exactly zero
    add_pixel(make_pix(200, 140, 141));  // negative hue wraps to 359
    add_pixel(make_pix(1, 0, 0));        // smallest delta
    add_pixel(make_pix(255, 254, 254));  // delta one at full value
    add_pixel(make_pix(128, 64, 200));   // blue max, red over green
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // idle profile: sender light, then receiver light, then none
      case (p / 2)
        0: begin send_idle_pct = 10; recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p)
        0: set_thresholds(0, 359, 0, 1000);
        1: begin
          set_thresholds(300, 30, 100, 900);
          // writes to unused indexes must change nothing
          write_reg(IDX_UNUSED_LOW, 10'd200);
          write_reg(IDX_UNUSED_TOP, 10'h3FF);
        end
        2: set_thresholds(20, 20, 500, 500);
        3: set_thresholds(10'h200, 10'h3FF, 0, 10'h3FF);  // masked and out-of-range bounds
        default: begin
          hlo = $urandom_range(359);
          slo = $urandom_range(1000);
          set_thresholds(hlo, $urandom_range(hlo, 359), slo, $urandom_range(slo, 1000));
        end
      endcase
      cfg_valid <= 1'b0;
      settings_used++;

      // random pixels, with one full drain halfway through
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if (i == RAND_ITEMS / 2) drain();
        add_pixel(random_pixel());
      end
      drain();
    end

    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d pixels over %0d threshold settings", pixels_sent, settings_used);
    $display("%0d results compared, %0d marked skin, %0d mismatches",
             results_seen, skin_seen, err_count);
    if (err_count == 0 && skin_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/hsc_pkg.sv
rtl/hsc_feature.sv
rtl/hsv_skin_pixel_classifier.sv
bench/testbench.sv
